### rtl/sllm_pkg.sv
// Shared types, constants and helpers for the static linked-list manager.
package sllm_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned NODE_W     = 4;
  localparam int unsigned OUT_W      = 32;

  typedef enum logic [1:0] {
    FUNC_NEW    = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_DELETE = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_NO_SUCC = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FETCH,
    OP_NEW,
    OP_INS_NEW,
    OP_INS_POS,
    OP_DEL_POS,
    OP_DEL_FREE,
    OP_READ,
    OP_ERR_FULL,
    OP_ERR_NOSUCC
  } op_e;

  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } link_t;

  typedef struct packed {
    op_e  op;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic fh_vld;
    logic la_vld;
  } dp_sts_t;

  // Link value of an entry that was never written: chain to the next node.
  function automatic link_t rst_link(logic [IDX_W-1:0] a);
    link_t l;
    l.vld = (32'(a) + 32'd1 < 32'(DEPTH));
    l.idx = l.vld ? IDX_W'(a + 1'b1) : '0;
    return l;
  endfunction

  // Reduce the 4-bit position into the pool by repeated subtraction.
  function automatic logic [IDX_W-1:0] pos_mod(logic [NODE_W-1:0] p);
    logic [NODE_W:0] v;
    v = {1'b0, p};
    if (DEPTH < 16) begin
      for (int k = 0; k < 8; k++) begin
        if (32'(v) >= 32'(DEPTH)) v = v - (NODE_W+1)'(DEPTH);
      end
    end
    return IDX_W'(v);
  endfunction

endpackage

### rtl/sllm_ctrl.sv
// Command sequencer for the linked-list manager.
module sllm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [1:0]       func_i,
  input  sllm_pkg::dp_sts_t sts_i,
  output sllm_pkg::cmd_t   cmd_o,
  output logic             busy
);
  import sllm_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_READ = 6'b000010,
    ST_INS2 = 6'b000100,
    ST_DEL1 = 6'b001000,
    ST_DEL2 = 6'b010000,
    ST_DEL3 = 6'b100000
  } state_e;

  state_e state_q, state_d;
  func_e  func_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      func_q  <= FUNC_NEW;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && start) func_q <= func_e'(func_i);
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    cmd_o.fin = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_READ;
        end
      end
      ST_READ: begin
        case (func_q)
          FUNC_NEW: begin
            cmd_o.op  = sts_i.fh_vld ? OP_NEW : OP_ERR_FULL;
            cmd_o.fin = 1'b1;
            state_d   = ST_IDLE;
          end
          FUNC_INSERT: begin
            if (sts_i.fh_vld) begin
              cmd_o.op = OP_INS_NEW;
              state_d  = ST_INS2;
            end else begin
              cmd_o.op  = OP_ERR_FULL;
              cmd_o.fin = 1'b1;
              state_d   = ST_IDLE;
            end
          end
          FUNC_DELETE: begin
            if (sts_i.la_vld) begin
              // fetch the link of the node being unlinked
              cmd_o.op = OP_FETCH;
              state_d  = ST_DEL1;
            end else begin
              cmd_o.op  = OP_ERR_NOSUCC;
              cmd_o.fin = 1'b1;
              state_d   = ST_IDLE;
            end
          end
          default: begin
            cmd_o.op  = OP_READ;
            cmd_o.fin = 1'b1;
            state_d   = ST_IDLE;
          end
        endcase
      end
      ST_INS2: begin
        cmd_o.op  = OP_INS_POS;
        cmd_o.fin = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_DEL1: begin
        cmd_o.op = OP_DEL_POS;
        state_d  = ST_DEL2;
      end
      ST_DEL2: begin
        cmd_o.op  = OP_DEL_FREE;
        cmd_o.fin = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

### rtl/sllm_dp.sv
// Node pool memories, free-list head and result registers.
module sllm_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sllm_pkg::cmd_t             cmd_i,
  input  logic [3:0]                 position_i,
  input  logic signed [31:0]         write_data_i,
  output sllm_pkg::dp_sts_t          sts_o,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [3:0]                 node_index_o,
  output logic signed [31:0]         read_data_o,
  output logic [3:0]                 next_index_o,
  output logic                       has_next_o
);
  import sllm_pkg::*;

  link_t                  lnk_mem [DEPTH];
  logic [DATA_WIDTH-1:0]  dat_mem [DEPTH];
  logic [DEPTH-1:0]       wr_q;

  link_t                  fh_q, fh_d;
  link_t                  rd_a_q, rd_b_q;
  logic signed [DATA_WIDTH-1:0] dat_q;
  logic [IDX_W-1:0]       pos_q, pos_in;
  logic signed [31:0]     wd_q;

  logic                   lnk_we, dat_we, rd_b_en;
  logic [IDX_W-1:0]       lnk_wa, rd_b_addr;
  link_t                  lnk_wd;

  logic                   done_q;
  logic [1:0]             status_q, status_d;
  logic [NODE_W-1:0]      node_q, next_q, node_d, next_d;
  logic signed [OUT_W-1:0] rdata_q, rdata_d;
  logic                   hn_q, hn_d;

  assign pos_in = pos_mod(position_i);

  always_comb begin
    lnk_we    = 1'b0;
    dat_we    = 1'b0;
    lnk_wa    = fh_q.idx;
    lnk_wd    = '0;
    fh_d      = fh_q;
    rd_b_en   = 1'b0;
    rd_b_addr = fh_q.idx;
    case (cmd_i.op)
      OP_LOAD: begin
        rd_b_en = 1'b1;
      end
      OP_FETCH: begin
        rd_b_en   = 1'b1;
        rd_b_addr = rd_a_q.idx;
      end
      OP_NEW: begin
        lnk_we = 1'b1;
        fh_d   = rd_b_q;
      end
      OP_INS_NEW: begin
        lnk_we = 1'b1;
        lnk_wd = rd_a_q;
        dat_we = 1'b1;
      end
      OP_INS_POS: begin
        lnk_we     = 1'b1;
        lnk_wa     = pos_q;
        lnk_wd.vld = 1'b1;
        lnk_wd.idx = fh_q.idx;
        fh_d       = rd_b_q;
      end
      OP_DEL_POS: begin
        lnk_we = 1'b1;
        lnk_wa = pos_q;
        lnk_wd = rd_b_q;
      end
      OP_DEL_FREE: begin
        lnk_we   = 1'b1;
        lnk_wa   = rd_a_q.idx;
        lnk_wd   = fh_q;
        fh_d.vld = 1'b1;
        fh_d.idx = rd_a_q.idx;
      end
      default: begin
      end
    endcase
  end

  // Memories: one write port, registered reads.
  always_ff @(posedge clk_i) begin
    if (lnk_we) lnk_mem[lnk_wa] <= lnk_wd;
    if (dat_we) dat_mem[fh_q.idx] <= DATA_WIDTH'(64'(wd_q));
    if (cmd_i.op == OP_LOAD) begin
      rd_a_q <= wr_q[pos_in] ? lnk_mem[pos_in] : rst_link(pos_in);
      dat_q  <= dat_mem[pos_in];
      pos_q  <= pos_in;
      wd_q   <= write_data_i;
    end
    if (rd_b_en) begin
      rd_b_q <= wr_q[rd_b_addr] ? lnk_mem[rd_b_addr] : rst_link(rd_b_addr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q       <= '0;
      fh_q.vld   <= 1'b1;
      fh_q.idx   <= '0;
      done_q     <= 1'b0;
    end else begin
      if (lnk_we) wr_q[lnk_wa] <= 1'b1;
      fh_q   <= fh_d;
      done_q <= cmd_i.fin;
    end
  end

  always_comb begin
    status_d = STS_OK;
    node_d   = '0;
    rdata_d  = '0;
    next_d   = '0;
    hn_d     = 1'b0;
    case (cmd_i.op)
      OP_NEW, OP_INS_POS: begin
        node_d = NODE_W'(fh_q.idx);
      end
      OP_DEL_FREE: begin
        node_d = NODE_W'(rd_a_q.idx);
      end
      OP_READ: begin
        node_d  = NODE_W'(pos_q);
        rdata_d = OUT_W'(64'(dat_q));
        hn_d    = rd_a_q.vld;
        next_d  = rd_a_q.vld ? NODE_W'(rd_a_q.idx) : '0;
      end
      OP_ERR_FULL: begin
        status_d = STS_NO_FREE;
      end
      OP_ERR_NOSUCC: begin
        status_d = STS_NO_SUCC;
      end
      default: begin
      end
    endcase
  end

  // Result registers, loaded on the last step of a command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      status_q <= status_d;
      node_q   <= node_d;
      rdata_q  <= rdata_d;
      next_q   <= next_d;
      hn_q     <= hn_d;
    end
  end

  assign sts_o.fh_vld = fh_q.vld;
  assign sts_o.la_vld = rd_a_q.vld;
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign node_index_o = node_q;
  assign read_data_o  = rdata_q;
  assign next_index_o = next_q;
  assign has_next_o   = hn_q;

endmodule

### rtl/static_linked_list_manager_top.sv
// Top level of the static linked-list manager: sequencer plus node-pool datapath.
// A command is taken when start is high and busy is low. new_list, read_node and
// any command that fails run the load and read steps; insert_after adds a link step,
// and delete_after the dependent fetch of the unlinked node and a step to free it,
// as the link memory has a single write port and registered reads. The result
// appears on the output ports for exactly one cycle with done_o high, the cycle
// after the command finishes; it cannot be held off, so capture it on done_o.
// busy is already low in that cycle, so the next command may start at once.
module static_linked_list_manager_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [3:0]         position_i,
  input  logic signed [31:0] write_data_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [3:0]         node_index_o,
  output logic signed [31:0] read_data_o,
  output logic [3:0]         next_index_o,
  output logic               has_next_o
);
  import sllm_pkg::*;

  cmd_t    cmd;
  dp_sts_t sts;

  sllm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  sllm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .position_i   (position_i),
    .write_data_i (write_data_i),
    .sts_o        (sts),
    .done_o       (done_o),
    .status_o     (status_o),
    .node_index_o (node_index_o),
    .read_data_o  (read_data_o),
    .next_index_o (next_index_o),
    .has_next_o   (has_next_o)
  );

endmodule
